// ===== hdl/tcs_pkg.sv =====
// Package for the timed RGB color sequencer.
// Holds the step record, request codes, play state and the queue control structs.
// No dependencies.
package tcs_pkg;

   // One queued color step: three duty values and a hold time in ticks.
   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] hold;
   } step_type;

   localparam int STEP_W = $bits(step_type);

   // Request kinds carried on req_type.
   localparam logic REQ_ADD  = 1'b0;
   localparam logic REQ_TICK = 1'b1;

   typedef enum logic {
      PLAY_IDLE   = 1'b0,
      PLAY_ACTIVE = 1'b1
   } play_state_type;

   // Commands from the player to the queue.
   typedef struct packed {
      logic push;
      logic pop;
   } queue_ctl_type;

   // Queue status seen by the player.
   typedef struct packed {
      logic tail_free;
      logic head_full;
   } queue_status_type;

endpackage

// ===== hdl/tcs_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Used for the step store of the color sequencer; no package dependency.
module tcs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/tcs_queue.sv =====
// Ring queue of color steps: slot flags, head and tail indices, step RAM.
// Depends on tcs_pkg and tcs_ram.
module tcs_queue
   import tcs_pkg::*;
#(
   parameter int QUEUE_DEPTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  queue_ctl_type    ctl,
   input  step_type         push_step,
   output queue_status_type status,
   output step_type         head_step
);

   localparam int IDX_W = $clog2(QUEUE_DEPTH);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_DEPTH - 1);

   logic [QUEUE_DEPTH-1:0] slot_full_ff, slot_full_in;
   logic [IDX_W-1:0]       head_ff, head_in;
   logic [IDX_W-1:0]       tail_ff, tail_in;
   logic                   fwd_valid_ff, fwd_valid_in;
   step_type               fwd_step_ff;
   logic [STEP_W-1:0]      ram_rd_data;

   always_comb begin
      slot_full_in = slot_full_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      if (ctl.push) begin
         slot_full_in[tail_ff] = 1'b1;
         tail_in = (tail_ff == LAST_IDX) ? '0 : tail_ff + 1'b1;
      end
      if (ctl.pop) begin
         slot_full_in[head_ff] = 1'b0;
         head_in = (head_ff == LAST_IDX) ? '0 : head_ff + 1'b1;
      end
   end

   // The RAM reads old data on a same-address write, so a step written
   // into the slot that becomes the head is forwarded from a side register.
   assign fwd_valid_in = ctl.push && (tail_ff == head_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_full_ff <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         fwd_valid_ff <= 1'b0;
      end else begin
         slot_full_ff <= slot_full_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         fwd_valid_ff <= fwd_valid_in;
      end
      fwd_step_ff <= push_step;
   end

   tcs_ram #(
      .WIDTH(STEP_W),
      .DEPTH(QUEUE_DEPTH)
   ) u_step_ram (
      .clock  (clock),
      .wr_en  (ctl.push),
      .wr_addr(tail_ff),
      .wr_data(push_step),
      .rd_addr(head_in),
      .rd_data(ram_rd_data)
   );

   assign head_step        = fwd_valid_ff ? fwd_step_ff : step_type'(ram_rd_data);
   assign status.tail_free = !slot_full_ff[tail_ff];
   assign status.head_full = slot_full_ff[head_ff];

endmodule

// ===== hdl/timed_rgb_color_sequencer.sv =====
// Timed RGB color sequencer: top level with play control and result register.
// The result strobe is registered at the accepting edge, so it is high in the cycle after the request was offered.
// Throughput: one transaction every cycle, as the queue is updated at every accepting edge.
// Synchronous active-high reset empties the queue, returns to idle, drives zero
// and clears enable; busy is high only while reset is asserted.
// Depends on tcs_pkg and tcs_queue. The receiver cannot stall the result strobe.
module timed_rgb_color_sequencer
   import tcs_pkg::*;
#(
   parameter int QUEUE_DEPTH = 8
) (
   input  logic       clock,
   input  logic       reset,
   // Input transaction channel.
   input  logic       start,
   output logic       busy,
   input  logic       req_type,
   input  logic [7:0] req_red_duty,
   input  logic [7:0] req_green_duty,
   input  logic [7:0] req_blue_duty,
   input  logic [7:0] req_hold_ticks,
   // Result channel, one strobe per accepted transaction.
   output logic       rsp_strobe,
   output logic       rsp_accepted,
   output logic [7:0] rsp_red_out,
   output logic [7:0] rsp_green_out,
   output logic [7:0] rsp_blue_out,
   output logic       rsp_playing,
   // Enable register write port.
   input  logic       csr_wr_en,
   input  logic       csr_wr_data
);

   play_state_type   state_ff, state_in;
   logic [7:0]       hold_ff, hold_in;
   logic [23:0]      drive_ff, drive_in;
   logic             enable_ff;
   logic             strobe_ff;
   logic             accepted_ff, accepted_in;
   logic             take;
   logic             is_add;
   logic             is_tick;
   queue_ctl_type    qctl;
   queue_status_type qstat;
   step_type         head_step;
   step_type         push_step;

   // A transaction is taken whenever start is high outside reset.
   assign busy    = reset;
   assign take    = start && !busy;
   assign is_add  = take && (req_type == REQ_ADD);
   // Ticks only count while the enable register is set.
   assign is_tick = take && (req_type == REQ_TICK) && enable_ff;

   assign push_step.red   = req_red_duty;
   assign push_step.green = req_green_duty;
   assign push_step.blue  = req_blue_duty;
   assign push_step.hold  = req_hold_ticks;

   // An add succeeds only when the write slot is free.
   assign accepted_in = qctl.push;

   // Play control. The running step's remaining hold time lives in hold_ff,
   // loaded from the head slot when the step starts, so the store is never
   // written back. When the count is exhausted a further tick frees the slot.
   always_comb begin
      state_in  = state_ff;
      hold_in   = hold_ff;
      drive_in  = drive_ff;
      qctl.push = is_add && qstat.tail_free;
      qctl.pop  = 1'b0;
      unique case (state_ff)
         PLAY_IDLE: begin
            if (is_tick) begin
               if (qstat.head_full) begin
                  drive_in = {head_step.red, head_step.green, head_step.blue};
                  hold_in  = (head_step.hold == 8'd0) ? 8'd0 : head_step.hold - 8'd1;
                  state_in = PLAY_ACTIVE;
               end else begin
                  drive_in = '0;
               end
            end
         end
         PLAY_ACTIVE: begin
            if (is_tick) begin
               if (hold_ff != 8'd0) begin
                  hold_in = hold_ff - 8'd1;
               end else begin
                  // The last color stays driven until the next tick.
                  qctl.pop = 1'b1;
                  state_in = PLAY_IDLE;
               end
            end
         end
         default: begin
            state_in = PLAY_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= PLAY_IDLE;
         drive_ff    <= '0;
         enable_ff   <= 1'b0;
         strobe_ff   <= 1'b0;
         accepted_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         drive_ff    <= drive_in;
         strobe_ff   <= take;
         accepted_ff <= accepted_in;
         if (csr_wr_en) begin
            enable_ff <= csr_wr_data;
         end
      end
      hold_ff <= hold_in;
   end

   tcs_queue #(
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .ctl      (qctl),
      .push_step(push_step),
      .status   (qstat),
      .head_step(head_step)
   );

   // The result reflects state after the transaction, registered at the
   // accepting edge and valid for the single strobe cycle that follows.
   assign rsp_strobe    = strobe_ff;
   assign rsp_accepted  = accepted_ff;
   assign rsp_red_out   = drive_ff[23:16];
   assign rsp_green_out = drive_ff[15:8];
   assign rsp_blue_out  = drive_ff[7:0];
   assign rsp_playing   = (state_ff == PLAY_ACTIVE);

endmodule

// ===== tb/sv/color_step_checker.sv =====
`timescale 1ns / 1ps
// Checker for the timed RGB color sequencer: watches the request, result and enable ports,
// predicts each result from its own copy of the step queue and compares field by field.
// Depends on tcs_pkg for the step record, request codes and play state.
module color_step_checker
   import tcs_pkg::*;
#(
   parameter int QUEUE_DEPTH = 8
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  logic       busy,
   input  logic       req_type,
   input  logic [7:0] req_red_duty,
   input  logic [7:0] req_green_duty,
   input  logic [7:0] req_blue_duty,
   input  logic [7:0] req_hold_ticks,
   input  logic       rsp_strobe,
   input  logic       rsp_accepted,
   input  logic [7:0] rsp_red_out,
   input  logic [7:0] rsp_green_out,
   input  logic [7:0] rsp_blue_out,
   input  logic       rsp_playing,
   input  logic       csr_wr_en,
   input  logic       csr_wr_data,
   output int         fail_count,
   output int         results_checked,
   output int         outstanding
);

   typedef struct packed {
      logic       accepted;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       playing;
   } color_result_type;

   step_type       step_ring [QUEUE_DEPTH];
   logic           ring_full [QUEUE_DEPTH];
   int             head_idx;
   int             tail_idx;
   play_state_type player;
   logic [7:0]     drive_red;
   logic [7:0]     drive_green;
   logic [7:0]     drive_blue;
   logic           seq_enable;

   color_result_type expected_colors [$];
   int               mismatches = 0;
   int               checked = 0;

   initial begin
      fail_count      = 0;
      results_checked = 0;
      outstanding     = 0;
   end

   function automatic int next_index(int idx);
      return (idx + 1 >= QUEUE_DEPTH) ? 0 : idx + 1;
   endfunction

   // Applies one request to the local queue copy and returns the result it should produce.
   function automatic color_result_type play_request(logic kind, step_type step);
      color_result_type res;
      int               h;
      int               t;
      h = head_idx;
      t = tail_idx;
      res.accepted = 1'b0;
      if (kind == REQ_ADD) begin
         if (!ring_full[t]) begin
            step_ring[t] = step;
            ring_full[t] = 1'b1;
            tail_idx     = next_index(t);
            res.accepted = 1'b1;
         end
      end else if (seq_enable) begin
         if (player == PLAY_IDLE) begin
            if (ring_full[h]) begin
               drive_red   = step_ring[h].red;
               drive_green = step_ring[h].green;
               drive_blue  = step_ring[h].blue;
               if (step_ring[h].hold != 8'd0) step_ring[h].hold = step_ring[h].hold - 8'd1;
               player = PLAY_ACTIVE;
            end else begin
               drive_red   = 8'd0;
               drive_green = 8'd0;
               drive_blue  = 8'd0;
            end
         end else begin
            if (step_ring[h].hold != 8'd0) begin
               step_ring[h].hold = step_ring[h].hold - 8'd1;
            end else begin
               ring_full[h] = 1'b0;
               head_idx     = next_index(h);
               player       = PLAY_IDLE;
            end
         end
      end
      res.red     = drive_red;
      res.green   = drive_green;
      res.blue    = drive_blue;
      res.playing = (player == PLAY_ACTIVE);
      return res;
   endfunction

   task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      color_result_type want;
      step_type         step;
      if (reset) begin
         for (int i = 0; i < QUEUE_DEPTH; i++) begin
            step_ring[i] = '0;
            ring_full[i] = 1'b0;
         end
         head_idx    = 0;
         tail_idx    = 0;
         player      = PLAY_IDLE;
         drive_red   = 8'd0;
         drive_green = 8'd0;
         drive_blue  = 8'd0;
         seq_enable  = 1'b0;
         expected_colors.delete();
      end else begin
         if (csr_wr_en) seq_enable = csr_wr_data;
         // The result of the previous transaction is compared before the new one is queued.
         if (rsp_strobe) begin
            if (expected_colors.size() == 0) begin
               $error("result strobe with no transaction outstanding");
               mismatches++;
            end else begin
               want = expected_colors.pop_front();
               check_field("rsp_accepted", {7'd0, want.accepted}, {7'd0, rsp_accepted});
               check_field("rsp_red_out", want.red, rsp_red_out);
               check_field("rsp_green_out", want.green, rsp_green_out);
               check_field("rsp_blue_out", want.blue, rsp_blue_out);
               check_field("rsp_playing", {7'd0, want.playing}, {7'd0, rsp_playing});
               checked++;
            end
         end
         if (start && !busy) begin
            step.red   = req_red_duty;
            step.green = req_green_duty;
            step.blue  = req_blue_duty;
            step.hold  = req_hold_ticks;
            expected_colors.push_back(play_request(req_type, step));
         end
      end
      fail_count      <= mismatches;
      results_checked <= checked;
      outstanding     <= expected_colors.size();
   end

endmodule

// ===== tb/sv/timed_rgb_color_sequencer_tb.sv =====
`timescale 1ns / 1ps
// Top of the testbench for the timed RGB color sequencer: clock, reset, stimulus and verdict.
// Depends on tcs_pkg, the sequencer RTL and color_step_checker.
module timed_rgb_color_sequencer_tb;
   import tcs_pkg::*;

   localparam int QUEUE_DEPTH = 8;
   // Cycles without any accepted transaction or result strobe before the run is declared hung.
   localparam int STALL_LIMIT = 500;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       start = 1'b0;
   logic       busy;
   logic       req_type = REQ_ADD;
   logic [7:0] req_red_duty = 8'd0;
   logic [7:0] req_green_duty = 8'd0;
   logic [7:0] req_blue_duty = 8'd0;
   logic [7:0] req_hold_ticks = 8'd0;
   logic       rsp_strobe;
   logic       rsp_accepted;
   logic [7:0] rsp_red_out;
   logic [7:0] rsp_green_out;
   logic [7:0] rsp_blue_out;
   logic       rsp_playing;
   logic       csr_wr_en = 1'b0;
   logic       csr_wr_data = 1'b0;

   int fail_count;
   int results_checked;
   int outstanding;
   int adds_sent = 0;
   int ticks_sent = 0;
   int enable_writes = 0;
   int quiet_cycles = 0;
   // When clear, the sender offers a new transaction on every cycle.
   bit gaps_on = 1'b1;

   always #5 clock = ~clock;

   timed_rgb_color_sequencer #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_top (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_type       (req_type),
      .req_red_duty   (req_red_duty),
      .req_green_duty (req_green_duty),
      .req_blue_duty  (req_blue_duty),
      .req_hold_ticks (req_hold_ticks),
      .rsp_strobe     (rsp_strobe),
      .rsp_accepted   (rsp_accepted),
      .rsp_red_out    (rsp_red_out),
      .rsp_green_out  (rsp_green_out),
      .rsp_blue_out   (rsp_blue_out),
      .rsp_playing    (rsp_playing),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data)
   );

   color_step_checker #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_checker (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_type        (req_type),
      .req_red_duty    (req_red_duty),
      .req_green_duty  (req_green_duty),
      .req_blue_duty   (req_blue_duty),
      .req_hold_ticks  (req_hold_ticks),
      .rsp_strobe      (rsp_strobe),
      .rsp_accepted    (rsp_accepted),
      .rsp_red_out     (rsp_red_out),
      .rsp_green_out   (rsp_green_out),
      .rsp_blue_out    (rsp_blue_out),
      .rsp_playing     (rsp_playing),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .fail_count      (fail_count),
      .results_checked (results_checked),
      .outstanding     (outstanding)
   );

   // Offers one transaction and returns at the edge that accepts it. Start is left high so
   // that a following transaction can go out back to back; it is only lowered for an idle
   // cycle or by the caller, never lowered and raised at the same edge.
   task automatic send_item(input logic kind, input logic [7:0] red, input logic [7:0] green,
                            input logic [7:0] blue, input logic [7:0] hold);
      while (gaps_on && $urandom_range(0, 99) < 21) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start          <= 1'b1;
      req_type       <= kind;
      req_red_duty   <= red;
      req_green_duty <= green;
      req_blue_duty  <= blue;
      req_hold_ticks <= hold;
      @(posedge clock);
      while (busy) @(posedge clock);
      if (kind == REQ_ADD) adds_sent++;
      else ticks_sent++;
   endtask

   // Writes the enable register once the sequencer is quiet. The first edge lets the
   // checker register the last accepted transaction; then every expected result must
   // have arrived before the write is made.
   task automatic write_enable(input logic value);
      start <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (2) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      enable_writes++;
   endtask

   // A run of random transactions. Adds mostly carry short hold times so that steps finish
   // and the ring wraps often; a few carry arbitrary or maximal hold times.
   task automatic run_phase(input int count, input int add_pct);
      logic       kind;
      logic [7:0] hold;
      int         pick;
      for (int i = 0; i < count; i++) begin
         kind = ($urandom_range(0, 99) < add_pct) ? REQ_ADD : REQ_TICK;
         pick = $urandom_range(0, 99);
         if (pick < 3) hold = 8'($urandom_range(0, 255));
         else if (pick < 4) hold = 8'd255;
         else hold = 8'($urandom_range(0, 3));
         send_item(kind, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)), hold);
      end
   endtask

   // Watchdog: a hung block or a lost result stops the run here.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("timed_rgb_color_sequencer: mismatch");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed part. Enable is still at its reset value, so ticks are ignored while the
      // first two steps, one all-zero and one at full duty with a hold of 1, go into the queue.
      send_item(REQ_TICK, 8'd0, 8'd0, 8'd0, 8'd0);
      send_item(REQ_ADD, 8'd0, 8'd0, 8'd0, 8'd0);
      send_item(REQ_ADD, 8'd255, 8'd255, 8'd255, 8'd1);
      send_item(REQ_TICK, 8'd255, 8'd255, 8'd255, 8'd255);
      write_enable(1'b1);
      // Start the zero-hold step, finish it, start the one-tick step, finish it, and then
      // tick on an empty queue, which drives zero.
      repeat (5) send_item(REQ_TICK, 8'd0, 8'd0, 8'd0, 8'd0);
      // Fill the whole ring across the wrap, then one add that finds the write slot full.
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         if (i % 2 == 0) send_item(REQ_ADD, 8'hAA, 8'h55, 8'hAA, 8'd0);
         else send_item(REQ_ADD, 8'h55, 8'hAA, 8'h55, 8'd0);
      end
      send_item(REQ_ADD, 8'd1, 8'd2, 8'd3, 8'd4);
      // Play and free three steps; the freed write slot then takes a new step.
      repeat (6) send_item(REQ_TICK, 8'd0, 8'd0, 8'd0, 8'd0);
      send_item(REQ_ADD, 8'd7, 8'd8, 8'd9, 8'd2);

      // Random part: balanced traffic, an add-heavy stretch that keeps the ring full,
      // a disabled stretch, a tick-heavy drain without sender gaps, and mixed traffic.
      run_phase(300, 50);
      run_phase(250, 80);
      write_enable(1'b0);
      run_phase(150, 50);
      write_enable(1'b1);
      gaps_on = 1'b0;
      run_phase(300, 25);
      gaps_on = 1'b1;
      run_phase(350, 50);
      write_enable(1'b1);
      run_phase(600, 45);

      // Drain: every result must arrive, then a few cycles for anything stray.
      start <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (4) @(posedge clock);

      $display("Sent %0d adds and %0d ticks across %0d enable writes; %0d results checked.",
               adds_sent, ticks_sent, enable_writes, results_checked);
      if (fail_count == 0 && outstanding == 0) begin
         $display("timed_rgb_color_sequencer: match");
      end else begin
         $display("timed_rgb_color_sequencer: mismatch");
      end
      $finish;
   end

endmodule
